// ----- hw/rtl/cvm_pkg.sv -----
`default_nettype none

package cvm_pkg;

  localparam int DATA_W     = 16;
  localparam int IDX_W      = 12;
  localparam int RESULT_W   = 32;
  localparam int ACC_W      = 48;
  localparam int MUL_W      = 18;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int OC_W       = 3;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;
  localparam int BIAS_SHIFT = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_CHANNELS  = 3'd0,
    REG_IN_HEIGHT    = 3'd1,
    REG_IN_WIDTH     = 3'd2,
    REG_OUT_CHANNELS = 3'd3,
    REG_KERNEL_SIZE  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    REQ_LOAD_WEIGHT = 2'd0,
    REQ_LOAD_BIAS   = 2'd1,
    REQ_LOAD_PIXEL  = 2'd2,
    REQ_EMIT        = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    SU_AREA,
    SU_KK,
    SU_CKK,
    SU_WBASE,
    SU_ROWOFF,
    SU_START
  } su_step_t;

endpackage

`default_nettype wire

// ----- hw/rtl/conv2d_valid_multichannel.sv -----
`default_nettype none

// Valid 2D convolution, stride 1, with one bias per output channel, on Q8.8 data. Load words
// (weight, bias, pixel) write their store at once and do not stall the input. An emit word
// occupies the block from its acceptance to the next accepted word, through the setup steps,
// one multiply-accumulate per kernel tap of each effective input channel and a drain, since
// one 18x18 multiplier does every multiply-accumulate in turn and is also used for the address
// products at the start; the pixel and weight memories give one word each per cycle. The
// input is stalled during that time, and longer while the finished result waits for a stalled
// output register. The stores have no reset and must be written before they are read.
module conv2d_valid_multichannel #(
  parameter int MAX_IN_CHANNELS  = 4,
  parameter int MAX_HEIGHT       = 32,
  parameter int MAX_WIDTH        = 32,
  parameter int MAX_OUT_CHANNELS = 8,
  parameter int MAX_KERNEL       = 5
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [cvm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [cvm_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            in_req_type,
  input  logic [cvm_pkg::IDX_W-1:0]             in_element_index,
  input  logic signed [cvm_pkg::DATA_W-1:0]     in_load_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [cvm_pkg::RESULT_W-1:0]   out_conv_value,
  output logic [cvm_pkg::OC_W-1:0]              out_out_channel_index,
  output logic [cvm_pkg::ROW_W-1:0]             out_out_row,
  output logic [cvm_pkg::COL_W-1:0]             out_out_col,
  output logic                                  out_last_output
);

  localparam int CW        = $clog2(MAX_IN_CHANNELS + 1);
  localparam int HW        = $clog2(MAX_HEIGHT + 1);
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int OCW       = $clog2(MAX_OUT_CHANNELS + 1);
  localparam int KW        = $clog2(MAX_KERNEL + 1);
  localparam int PIX_DEPTH = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int WGT_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
  localparam int PA_W      = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
  localparam int WA_W      = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
  localparam int BA_W      = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
  localparam int IC_W      = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
  localparam int KI_W      = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;

  localparam logic signed [cvm_pkg::ACC_W-1:0] SAT_MAX = cvm_pkg::ACC_W'(64'sd2147483647);
  localparam logic signed [cvm_pkg::ACC_W-1:0] SAT_MIN = -cvm_pkg::ACC_W'(64'sd2147483648);

  logic signed [cvm_pkg::DATA_W-1:0] pixel_mem  [PIX_DEPTH];
  logic signed [cvm_pkg::DATA_W-1:0] weight_mem [WGT_DEPTH];
  logic signed [cvm_pkg::DATA_W-1:0] bias_mem   [MAX_OUT_CHANNELS];

  cvm_pkg::state_t   state_r, state_nxt;
  cvm_pkg::su_step_t step_r, step_nxt;

  logic [2:0] in_channels_r;
  logic [5:0] in_height_r;
  logic [5:0] in_width_r;
  logic [3:0] out_channels_r;
  logic [2:0] kernel_side_r;

  logic [CW-1:0]  c_eff;
  logic [HW-1:0]  h_eff, ho_eff;
  logic [WW-1:0]  w_eff, wo_eff;
  logic [OCW-1:0] oc_eff;
  logic [KW-1:0]  k_clamp, k_eff;

  logic [cvm_pkg::OC_W-1:0]  oc_r, oc_nxt;
  logic [cvm_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [cvm_pkg::COL_W-1:0] col_r, col_nxt;

  logic [IC_W-1:0] ic_r, ic_nxt;
  logic [KI_W-1:0] kr_r, kr_nxt, kc_r, kc_nxt;
  logic [PA_W-1:0] pix_addr_r, pix_addr_nxt, row_base_r, row_base_nxt;
  logic [PA_W-1:0] chan_base_r, chan_base_nxt, hw_r, hw_nxt;
  logic [WA_W-1:0] wgt_addr_r, wgt_addr_nxt;

  logic signed [cvm_pkg::DATA_W-1:0] pix_q, wgt_q, bias_q;
  logic signed [cvm_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [cvm_pkg::PROD_W-1:0] prod_r;
  logic                              rd_v_r, prod_v_r;
  logic signed [cvm_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [cvm_pkg::RESULT_W-1:0] sat_value;

  logic out_valid_r, out_valid_nxt, out_load;
  logic signed [cvm_pkg::RESULT_W-1:0] out_conv_value_r;
  logic [cvm_pkg::OC_W-1:0]  out_oc_r;
  logic [cvm_pkg::ROW_W-1:0] out_row_r;
  logic [cvm_pkg::COL_W-1:0] out_col_r;
  logic                      out_last_r, last_now;

  logic in_accept, emit_accept, out_of_range;
  logic kc_last, kr_last, ic_last, col_last, row_last, oc_last;

  assign in_stall  = (state_r != cvm_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign emit_accept = in_accept && (in_req_type == cvm_pkg::REQ_EMIT);

  always_comb begin
    if (in_channels_r == '0) begin
      c_eff = CW'(1);
    end else if (32'(in_channels_r) > MAX_IN_CHANNELS) begin
      c_eff = CW'(MAX_IN_CHANNELS);
    end else begin
      c_eff = CW'(in_channels_r);
    end
    if (in_height_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(in_height_r) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(in_height_r);
    end
    if (in_width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(in_width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(in_width_r);
    end
    if (out_channels_r == '0) begin
      oc_eff = OCW'(1);
    end else if (32'(out_channels_r) > MAX_OUT_CHANNELS) begin
      oc_eff = OCW'(MAX_OUT_CHANNELS);
    end else begin
      oc_eff = OCW'(out_channels_r);
    end
    if (kernel_side_r == '0) begin
      k_clamp = KW'(1);
    end else if (32'(kernel_side_r) > MAX_KERNEL) begin
      k_clamp = KW'(MAX_KERNEL);
    end else begin
      k_clamp = KW'(kernel_side_r);
    end
    k_eff = k_clamp;
    if (32'(k_eff) > 32'(h_eff)) begin
      k_eff = KW'(h_eff);
    end
    if (32'(k_eff) > 32'(w_eff)) begin
      k_eff = KW'(w_eff);
    end
    ho_eff = HW'(32'(h_eff) + 1 - 32'(k_eff));
    wo_eff = WW'(32'(w_eff) + 1 - 32'(k_eff));
  end

  assign out_of_range = (32'(oc_r) >= 32'(oc_eff)) || (32'(row_r) >= 32'(ho_eff)) ||
                        (32'(col_r) >= 32'(wo_eff));

  assign kc_last  = (kc_r == KI_W'(32'(k_eff) - 1));
  assign kr_last  = (kr_r == KI_W'(32'(k_eff) - 1));
  assign ic_last  = (ic_r == IC_W'(32'(c_eff) - 1));
  assign col_last = (32'(col_r) == 32'(wo_eff) - 1);
  assign row_last = (32'(row_r) == 32'(ho_eff) - 1);
  assign oc_last  = (32'(oc_r) == 32'(oc_eff) - 1);
  assign last_now = col_last && row_last && oc_last;

  always_comb begin
    if (acc_r > SAT_MAX) begin
      sat_value = cvm_pkg::RESULT_W'(SAT_MAX);
    end else if (acc_r < SAT_MIN) begin
      sat_value = cvm_pkg::RESULT_W'(SAT_MIN);
    end else begin
      sat_value = cvm_pkg::RESULT_W'(acc_r);
    end
  end

  // The multiplier forms the address products during setup and the data products otherwise.
  always_comb begin
    mul_a = cvm_pkg::MUL_W'(pix_q);
    mul_b = cvm_pkg::MUL_W'(wgt_q);
    if (state_r == cvm_pkg::ST_SETUP) begin
      unique case (step_r)
        cvm_pkg::SU_AREA: begin
          mul_a = cvm_pkg::MUL_W'(h_eff);
          mul_b = cvm_pkg::MUL_W'(w_eff);
        end
        cvm_pkg::SU_KK: begin
          mul_a = cvm_pkg::MUL_W'(k_eff);
          mul_b = cvm_pkg::MUL_W'(k_eff);
        end
        cvm_pkg::SU_CKK: begin
          mul_a = cvm_pkg::MUL_W'(c_eff);
          mul_b = cvm_pkg::MUL_W'(prod_r);
        end
        cvm_pkg::SU_WBASE: begin
          mul_a = cvm_pkg::MUL_W'(oc_r);
          mul_b = cvm_pkg::MUL_W'(prod_r);
        end
        cvm_pkg::SU_ROWOFF: begin
          mul_a = cvm_pkg::MUL_W'(row_r);
          mul_b = cvm_pkg::MUL_W'(w_eff);
        end
        default: begin
          mul_a = cvm_pkg::MUL_W'(pix_q);
          mul_b = cvm_pkg::MUL_W'(wgt_q);
        end
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    oc_nxt        = oc_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    ic_nxt        = ic_r;
    kr_nxt        = kr_r;
    kc_nxt        = kc_r;
    pix_addr_nxt  = pix_addr_r;
    row_base_nxt  = row_base_r;
    chan_base_nxt = chan_base_r;
    hw_nxt        = hw_r;
    wgt_addr_nxt  = wgt_addr_r;
    acc_nxt       = acc_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    if (prod_v_r) begin
      acc_nxt = acc_r + cvm_pkg::ACC_W'(prod_r);
    end
    unique case (state_r)
      cvm_pkg::ST_IDLE: begin
        if (emit_accept) begin
          if (out_of_range) begin
            oc_nxt  = '0;
            row_nxt = '0;
            col_nxt = '0;
          end
          step_nxt  = cvm_pkg::SU_AREA;
          state_nxt = cvm_pkg::ST_SETUP;
        end
      end
      cvm_pkg::ST_SETUP: begin
        unique case (step_r)
          cvm_pkg::SU_AREA: begin
            step_nxt = cvm_pkg::SU_KK;
          end
          cvm_pkg::SU_KK: begin
            hw_nxt   = PA_W'(prod_r);
            step_nxt = cvm_pkg::SU_CKK;
          end
          cvm_pkg::SU_CKK: begin
            step_nxt = cvm_pkg::SU_WBASE;
          end
          cvm_pkg::SU_WBASE: begin
            step_nxt = cvm_pkg::SU_ROWOFF;
          end
          cvm_pkg::SU_ROWOFF: begin
            wgt_addr_nxt = WA_W'(prod_r);
            step_nxt     = cvm_pkg::SU_START;
          end
          default: begin
            pix_addr_nxt  = PA_W'(prod_r) + PA_W'(col_r);
            row_base_nxt  = PA_W'(prod_r) + PA_W'(col_r);
            chan_base_nxt = PA_W'(prod_r) + PA_W'(col_r);
            ic_nxt        = '0;
            kr_nxt        = '0;
            kc_nxt        = '0;
            acc_nxt       = cvm_pkg::ACC_W'(bias_q) <<< cvm_pkg::BIAS_SHIFT;
            state_nxt     = cvm_pkg::ST_RUN;
          end
        endcase
      end
      cvm_pkg::ST_RUN: begin
        wgt_addr_nxt = wgt_addr_r + WA_W'(1);
        if (!kc_last) begin
          kc_nxt       = kc_r + KI_W'(1);
          pix_addr_nxt = pix_addr_r + PA_W'(1);
        end else begin
          kc_nxt = '0;
          if (!kr_last) begin
            kr_nxt       = kr_r + KI_W'(1);
            row_base_nxt = row_base_r + PA_W'(w_eff);
            pix_addr_nxt = row_base_r + PA_W'(w_eff);
          end else begin
            kr_nxt = '0;
            if (!ic_last) begin
              ic_nxt        = ic_r + IC_W'(1);
              chan_base_nxt = chan_base_r + hw_r;
              row_base_nxt  = chan_base_r + hw_r;
              pix_addr_nxt  = chan_base_r + hw_r;
            end else begin
              state_nxt = cvm_pkg::ST_DRAIN;
            end
          end
        end
      end
      cvm_pkg::ST_DRAIN: begin
        if (!rd_v_r && !prod_v_r) begin
          state_nxt = cvm_pkg::ST_DONE;
        end
      end
      cvm_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = cvm_pkg::ST_IDLE;
          if (!col_last) begin
            col_nxt = col_r + cvm_pkg::COL_W'(1);
          end else begin
            col_nxt = '0;
            if (!row_last) begin
              row_nxt = row_r + cvm_pkg::ROW_W'(1);
            end else begin
              row_nxt = '0;
              oc_nxt  = oc_last ? '0 : oc_r + cvm_pkg::OC_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = cvm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= cvm_pkg::ST_IDLE;
      step_r         <= cvm_pkg::SU_AREA;
      rd_v_r         <= 1'b0;
      prod_v_r       <= 1'b0;
      out_valid_r    <= 1'b0;
      oc_r           <= '0;
      row_r          <= '0;
      col_r          <= '0;
      in_channels_r  <= 3'd1;
      in_height_r    <= 6'd32;
      in_width_r     <= 6'd32;
      out_channels_r <= 4'd1;
      kernel_side_r  <= 3'd3;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      rd_v_r      <= (state_r == cvm_pkg::ST_RUN);
      prod_v_r    <= rd_v_r;
      out_valid_r <= out_valid_nxt;
      oc_r        <= oc_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      if (cfg_we) begin
        unique case (cvm_pkg::cfg_reg_t'(cfg_index))
          cvm_pkg::REG_IN_CHANNELS:  in_channels_r  <= cfg_data[2:0];
          cvm_pkg::REG_IN_HEIGHT:    in_height_r    <= cfg_data[5:0];
          cvm_pkg::REG_IN_WIDTH:     in_width_r     <= cfg_data[5:0];
          cvm_pkg::REG_OUT_CHANNELS: out_channels_r <= cfg_data[3:0];
          cvm_pkg::REG_KERNEL_SIZE:  kernel_side_r  <= cfg_data[2:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ic_r        <= ic_nxt;
    kr_r        <= kr_nxt;
    kc_r        <= kc_nxt;
    pix_addr_r  <= pix_addr_nxt;
    row_base_r  <= row_base_nxt;
    chan_base_r <= chan_base_nxt;
    hw_r        <= hw_nxt;
    wgt_addr_r  <= wgt_addr_nxt;
    acc_r       <= acc_nxt;
    prod_r      <= mul_a * mul_b;
    if (out_load) begin
      out_conv_value_r <= sat_value;
      out_oc_r         <= oc_r;
      out_row_r        <= row_r;
      out_col_r        <= col_r;
      out_last_r       <= last_now;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && (in_req_type == cvm_pkg::REQ_LOAD_PIXEL) &&
        (32'(in_element_index) < PIX_DEPTH)) begin
      pixel_mem[PA_W'(in_element_index)] <= in_load_value;
    end
    pix_q <= pixel_mem[pix_addr_r];
  end

  always_ff @(posedge clk) begin
    if (in_accept && (in_req_type == cvm_pkg::REQ_LOAD_WEIGHT) &&
        (32'(in_element_index) < WGT_DEPTH)) begin
      weight_mem[WA_W'(in_element_index)] <= in_load_value;
    end
    wgt_q <= weight_mem[wgt_addr_r];
  end

  always_ff @(posedge clk) begin
    if (in_accept && (in_req_type == cvm_pkg::REQ_LOAD_BIAS) &&
        (32'(in_element_index) < MAX_OUT_CHANNELS)) begin
      bias_mem[BA_W'(in_element_index)] <= in_load_value;
    end
    bias_q <= bias_mem[BA_W'(oc_r)];
  end

  assign out_valid             = out_valid_r;
  assign out_conv_value        = out_conv_value_r;
  assign out_out_channel_index = out_oc_r;
  assign out_out_row           = out_row_r;
  assign out_out_col           = out_col_r;
  assign out_last_output       = out_last_r;

endmodule

`default_nettype wire

// ----- hw/rtl/cvm_checker.sv -----
`default_nettype none

module cvm_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic [1:0]                          in_req_type,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [cvm_pkg::RESULT_W-1:0] out_conv_value,
  input logic [cvm_pkg::OC_W-1:0]            out_out_channel_index,
  input logic [cvm_pkg::ROW_W-1:0]           out_out_row,
  input logic [cvm_pkg::COL_W-1:0]           out_out_col,
  input logic                                out_last_output
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_conv_value) &&
    $stable(out_out_channel_index) && $stable(out_out_row) && $stable(out_out_col) &&
    $stable(out_last_output))
    else $error("stalled result word changed");

  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req_type == cvm_pkg::REQ_EMIT) |=> in_stall)
    else $error("emit word did not make the block busy");

  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req_type != cvm_pkg::REQ_EMIT) |=> !in_stall)
    else $error("load word did not finish in one cycle");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word appeared without an emit in progress");

endmodule

bind conv2d_valid_multichannel cvm_checker u_cvm_checker (.*);

`default_nettype wire
